/* sv/gce16_pkg.sv */
// Shared types and constants for the 16bpp glyph color expander.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gce16_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FRAME_BASE   = 2'd0,
    REG_LINE_BYTES   = 2'd1,
    REG_WIDTH_SELECT = 2'd2,
    REG_FONT_HEIGHT  = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [31:0] FrameBaseRst   = 32'd0;
  localparam logic [14:0] LineBytesRst   = 15'd2048;
  localparam logic [1:0]  WidthSelectRst = 2'd1;
  localparam logic [5:0]  FontHeightRst  = 6'd16;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [14:0] line_bytes;
    logic [1:0]  width_select;
    logic [5:0]  font_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [4:0]  glyph_line;
    logic [15:0] glyph_bits;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] byte_addr;
    logic [31:0] pixel_pair;
    logic        last_word;
  } out_item_t;

  // One classified glyph line waiting for the back end.
  typedef struct packed {
    logic [31:0] base_addr;
    logic [1:0]  width_select;
    logic [15:0] glyph_bits;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
  } line_entry_t;

endpackage

`default_nettype wire

/* sv/gce16_front.sv */
// Front end: accepts glyph lines and computes the start byte address in two stages.
// Depends on gce16_pkg.
`default_nettype none

module gce16_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gce16_pkg::cfg_t       cfg_i,
  input  logic                  in_valid_i,
  input  gce16_pkg::in_item_t   in_item_i,
  output logic                  push_o,
  output gce16_pkg::line_entry_t entry_o,
  output logic [1:0]            inflight_o
);
  import gce16_pkg::*;

  logic        s1_valid_q;
  logic [13:0] line_idx_q, line_idx_d;
  logic [12:0] col_off_q, col_off_d;
  logic [15:0] bits_q, fg_q, bg_q;
  logic [1:0]  ws_q;

  logic        s2_valid_q;
  line_entry_t entry_q, entry_d;

  logic [12:0] row_mul;
  logic [10:0] col_mul;
  logic [28:0] line_prod;

  // Stage one: scan line index and column byte offset (col * width * 2).
  always_comb begin
    row_mul    = 13'({6'b0, in_item_i.cell_row} * {7'b0, cfg_i.font_height});
    line_idx_d = {1'b0, row_mul} + {9'b0, in_item_i.glyph_line};
    col_mul    = {3'b0, in_item_i.cell_col} * {8'b0, ({1'b0, cfg_i.width_select} + 3'd1)};
    col_off_d  = {col_mul[9:0], 3'b000};
  end

  // Stage two: scale by the line pitch and add the frame base.
  always_comb begin
    line_prod              = 29'({15'b0, line_idx_q} * {14'b0, cfg_i.line_bytes});
    entry_d.base_addr      = cfg_i.frame_base + {3'b0, line_prod} + {19'b0, col_off_q};
    entry_d.width_select   = ws_q;
    entry_d.glyph_bits     = bits_q;
    entry_d.fg_color       = fg_q;
    entry_d.bg_color       = bg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    line_idx_q <= line_idx_d;
    col_off_q  <= col_off_d;
    bits_q     <= in_item_i.glyph_bits;
    fg_q       <= in_item_i.fg_color;
    bg_q       <= in_item_i.bg_color;
    ws_q       <= cfg_i.width_select;
    entry_q    <= entry_d;
  end

  assign push_o     = s2_valid_q;
  assign entry_o    = entry_q;
  assign inflight_o = {1'b0, s1_valid_q} + {1'b0, s2_valid_q};

endmodule

`default_nettype wire

/* sv/gce16_queue.sv */
// Line queue between front and back ends; reserves room for lines still in the front pipe.
// Depends on gce16_pkg.
`default_nettype none

module gce16_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gce16_pkg::line_entry_t entry_i,
  input  logic [1:0]             inflight_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output gce16_pkg::line_entry_t head_o,
  output logic                   empty_o
);
  import gce16_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  line_entry_t          entries_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW+1:0]      committed;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  // The front pipe never stalls, so a new transaction needs a slot for
  // every line already inside it.
  assign committed = {2'b0, cnt_q} + {{CntW{1'b0}}, inflight_i};
  assign full_o    = committed >= (CntW+2)'(Depth);
  assign head_o    = entries_q[rd_ptr_q];
  assign empty_o   = (cnt_q == '0);

endmodule

`default_nettype wire

/* sv/gce16_back.sv */
// Back end: expands one queued glyph line into 32-bit pixel pair words, one per cycle unless the result side stalls.
// Depends on gce16_pkg.
`default_nettype none

module gce16_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gce16_pkg::line_entry_t head_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output gce16_pkg::out_item_t   out_item_o
);
  import gce16_pkg::*;

  logic [2:0]  word_q, word_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        load;
  logic        is_last;
  logic [15:0] bits_sh;
  logic [15:0] left_px, right_px;

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign is_last = (word_q == {head_i.width_select, 1'b1});

  always_comb begin
    bits_sh           = head_i.glyph_bits << {word_q, 1'b0};
    left_px           = bits_sh[15] ? head_i.fg_color : head_i.bg_color;
    right_px          = bits_sh[14] ? head_i.fg_color : head_i.bg_color;
    out_d.byte_addr   = head_i.base_addr + {27'b0, word_q, 2'b00};
    out_d.pixel_pair  = {right_px, left_px};
    out_d.last_word   = is_last;
  end

  always_comb begin
    word_d      = word_q;
    out_valid_d = out_valid_q;
    if (pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      word_d      = is_last ? 3'd0 : word_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign q_pop_o    = load && is_last;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

endmodule

`default_nettype wire

/* sv/glyph_color_expand_16bpp_top.sv */
// Top level of the 16bpp glyph color expander: configuration registers and the
// front end, line queue and back end. Depends on gce16_pkg and the gce16_* modules.
//
//   channel   handshake            payload
//   input     push_i / full_o      in_data_i  (in_item_t)
//   result    empty_o / pop_i      out_data_o (out_item_t)
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//
// The back end writes one word per cycle into its output register unless the result
// side stalls, so a glyph line gives 2, 4, 6 or 8 words for font widths 4, 8, 12 and 16.
// The first word passes through the two address stages, the queue write and the output
// register in that order before it can be taken. Reset loads the documented register
// values and empties every stage.
// A stalled result side fills the queue, then raises full_o.
`default_nettype none

module glyph_color_expand_16bpp_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  gce16_pkg::in_item_t                 in_data_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output gce16_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gce16_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gce16_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import gce16_pkg::*;

  cfg_t        cfg_q;
  logic        accept;
  logic        q_push, q_pop, q_empty;
  logic [1:0]  inflight;
  line_entry_t q_entry, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base   <= FrameBaseRst;
      cfg_q.line_bytes   <= LineBytesRst;
      cfg_q.width_select <= WidthSelectRst;
      cfg_q.font_height  <= FontHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_BASE:   cfg_q.frame_base   <= cfg_wdata_i;
        REG_LINE_BYTES:   cfg_q.line_bytes   <= cfg_wdata_i[14:0];
        REG_WIDTH_SELECT: cfg_q.width_select <= cfg_wdata_i[1:0];
        REG_FONT_HEIGHT:  cfg_q.font_height  <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign accept = push_i && !full_o;

  gce16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (accept),
    .in_item_i  (in_data_i),
    .push_o     (q_push),
    .entry_o    (q_entry),
    .inflight_o (inflight)
  );

  gce16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .entry_i    (q_entry),
    .inflight_i (inflight),
    .full_o     (full_o),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  gce16_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for glyph_color_expand_16bpp_top: drives glyph lines and
// register writes, and predicts every pixel word with its byte address.
// Depends on gce16_pkg and the RTL of the expander.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gce16_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports = 10;

  // Expected pixel words, in order, plus the register copy used to predict them.
  class word_scoreboard;
    cfg_t regs;
    out_item_t words_due[$];
    int unsigned lines_seen;
    int unsigned words_seen;
    int unsigned errors;
    int unsigned width_lines[4];

    function new();
      regs.frame_base = FrameBaseRst;
      regs.line_bytes = LineBytesRst;
      regs.width_select = WidthSelectRst;
      regs.font_height = FontHeightRst;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_FRAME_BASE:   regs.frame_base = val;
        REG_LINE_BYTES:   regs.line_bytes = val[14:0];
        REG_WIDTH_SELECT: regs.width_select = val[1:0];
        REG_FONT_HEIGHT:  regs.font_height = val[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return words_due.size();
    endfunction

    // Expands one accepted glyph line into the words it must produce.
    function void expand_line(in_item_t item);
      int unsigned npix;
      int unsigned nwords;
      logic [63:0] addr;
      logic [15:0] left;
      logic [15:0] right;
      out_item_t w;
      npix = 4 * (int'(regs.width_select) + 1);
      nwords = npix / 2;
      addr = 64'(regs.frame_base)
           + (64'(item.cell_row) * 64'(regs.font_height) + 64'(item.glyph_line))
             * 64'(regs.line_bytes)
           + 64'(item.cell_col) * 64'(npix) * 64'd2;
      for (int unsigned k = 0; k < nwords; k++) begin
        left = item.glyph_bits[15 - 2 * k] ? item.fg_color : item.bg_color;
        right = item.glyph_bits[14 - 2 * k] ? item.fg_color : item.bg_color;
        w.byte_addr = addr[31:0] + 32'(4 * k);
        w.pixel_pair = {right, left};
        w.last_word = (k + 1 == nwords);
        words_due.push_back(w);
      end
      lines_seen++;
      width_lines[regs.width_select]++;
    endfunction

    function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
      errors++;
      if (errors <= MaxReports) begin
        $display("[%0t] %s: expected %h, got %h", $realtime, what, exp_val, got_val);
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t exp_w;
      words_seen++;
      if (words_due.size() == 0) begin
        flag("word with nothing due, address", 32'd0, got.byte_addr);
      end else begin
        exp_w = words_due.pop_front();
        if (got.byte_addr !== exp_w.byte_addr) begin
          flag("byte_addr", exp_w.byte_addr, got.byte_addr);
        end
        if (got.pixel_pair !== exp_w.pixel_pair) begin
          flag("pixel_pair", exp_w.pixel_pair, got.pixel_pair);
        end
        if (got.last_word !== exp_w.last_word) begin
          flag("last_word", 32'(exp_w.last_word), 32'(got.last_word));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push_i;
  logic full_o;
  in_item_t in_data_i;
  logic empty_o;
  logic pop_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  word_scoreboard sb;
  bit calm;
  int unsigned cycles;
  int unsigned settings;

  glyph_color_expand_16bpp_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_data_i   (in_data_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 14);
  endfunction

  function automatic in_item_t line_of(logic [7:0] col, logic [6:0] row, logic [4:0] gline,
                                       logic [15:0] bits, logic [15:0] fg, logic [15:0] bg);
    in_item_t it;
    it.cell_col = col;
    it.cell_row = row;
    it.glyph_line = gline;
    it.glyph_bits = bits;
    it.fg_color = fg;
    it.bg_color = bg;
    return it;
  endfunction

  function automatic in_item_t random_line();
    return line_of(8'($urandom), 7'($urandom), 5'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // Both handshakes are sampled here, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) begin
        sb.expand_line(in_data_i);
      end
      if (pop_i && !empty_o) begin
        sb.check_word(out_data_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d words still due", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: pop is held high except for random stalls.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop_i = !take_break();
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_line(input in_item_t item);
    while (take_break()) begin
      push_i = 1'b0;
      in_data_i = random_line();
      @(negedge clk_i);
    end
    push_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_line(random_line());
  endtask

  // Waits until every expected word has come out, then lets the pipeline go quiet.
  task automatic settle();
    push_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Unused upper data bits carry noise so that register masking is exercised.
  task automatic configure(input logic [31:0] base, input logic [14:0] pitch,
                           input logic [1:0] wsel, input logic [5:0] height);
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_LINE_BYTES, {17'($urandom), pitch});
    write_reg(REG_WIDTH_SELECT, {30'($urandom), wsel});
    write_reg(REG_FONT_HEIGHT, {26'($urandom), height});
    cfg_we_i = 1'b0;
    settings++;
  endtask

  task automatic configure_random();
    logic [5:0] height;
    height = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(1, 32));
    configure($urandom, 15'($urandom), 2'($urandom), height);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    settings = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    push_i = 1'b0;
    pop_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FRAME_BASE;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values of the registers.
    send_line(line_of(8'd0, 7'd0, 5'd0, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_line(line_of(8'd255, 7'd127, 5'd31, 16'h0000, 16'h0000, 16'hFFFF));
    send_line(line_of(8'd1, 7'd2, 5'd3, 16'hA5C3, 16'h1234, 16'hABCD));
    settle();

    // Narrowest font, zero pitch, height of one; low glyph bits must be ignored.
    configure(32'h0000_0000, 15'd0, 2'd0, 6'd1);
    send_line(line_of(8'd0, 7'd0, 5'd0, 16'hF0FF, 16'hFFFF, 16'h0000));
    send_line(line_of(8'd255, 7'd127, 5'd31, 16'h5FFF, 16'hFFFF, 16'h0001));
    send_line(line_of(8'd17, 7'd5, 5'd9, 16'h9000, 16'h8000, 16'h7FFF));
    settle();

    // Widest font, pitch and height at their top values, frame base near the top: the address wraps.
    configure(32'hFFFF_FFF0, 15'h7FFF, 2'd3, 6'd63);
    send_line(line_of(8'd255, 7'd127, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_line(line_of(8'd255, 7'd127, 5'd31, 16'h8001, 16'h0000, 16'hFFFF));
    send_line(line_of(8'd0, 7'd0, 5'd0, 16'h5555, 16'hAAAA, 16'h5555));
    send_line(line_of(8'd128, 7'd64, 5'd16, 16'hAAAA, 16'h0F0F, 16'hF0F0));
    settle();

    // Zero font height collapses the row term.
    configure(32'h1000_0000, 15'd1280, 2'd2, 6'd0);
    send_line(line_of(8'd10, 7'd100, 5'd31, 16'h3C3F, 16'hC3C3, 16'h3C3C));
    send_line(line_of(8'd255, 7'd127, 5'd0, 16'hFFF0, 16'h0001, 16'h8000));
    send_line(line_of(8'd0, 7'd1, 5'd1, 16'h000F, 16'h00FF, 16'hFF00));
    settle();

    // Glyph line at or beyond the font height still enters the address.
    configure(32'h8000_0000, 15'd2048, 2'd1, 6'd8);
    send_line(line_of(8'd3, 7'd4, 5'd31, 16'hC000, 16'h7E0F, 16'h81F0));
    send_line(line_of(8'd0, 7'd127, 5'd8, 16'h0100, 16'hFFFE, 16'h0001));
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      configure_random();
      calm = (phase == 2);
      send_random(40);
      settle();
    end
    calm = 1'b0;

    $display("Covered %0d glyph lines (%0d/%0d/%0d/%0d at widths 4/8/12/16), %0d words,",
             sb.lines_seen, sb.width_lines[0], sb.width_lines[1], sb.width_lines[2],
             sb.width_lines[3], sb.words_seen);
    $display("over %0d register settings plus reset values; %0d mismatches.",
             settings, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
